>>> design/allm_pkg.sv
package allm_pkg;

    typedef logic [2:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_INS_AFTER   = 3'd0;
    localparam opcode_t OP_INS_BEFORE  = 3'd1;
    localparam opcode_t OP_ERASE       = 3'd2;
    localparam opcode_t OP_ERASE_FRONT = 3'd3;
    localparam opcode_t OP_ERASE_BACK  = 3'd4;
    localparam opcode_t OP_READ        = 3'd5;
    localparam opcode_t OP_FIND        = 3'd6;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_BAD_SLOT = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_BAD_POS  = 2'd3;

endpackage

>>> design/array_linked_list_manager_unit.sv
// Path from accepted start to the done strobe: read and any error end in S_CHK, the erase
// operations pass S_CHK and S_LINK, the inserts S_CHK, S_ALLOC and S_LINK, find walks S_WALK.
// Throughput: one word at a time; the link stores have one read and one write port,
// so find walks one link per cycle. start is taken again in the cycle done is high.
// rst_n clears the control state, the sentinel links, free head, high-water mark and count;
// the slot stores are not cleared, slots at or above the high-water mark read as never used.
module array_linked_list_manager_unit #(
    parameter int CAPACITY   = 255,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  allm_pkg::opcode_t       opcode,
    input  logic [7:0]              slot,
    input  logic [7:0]              position,
    input  logic signed [31:0]      value,
    output logic                    done,
    output allm_pkg::status_t       status,
    output logic [7:0]              result_slot,
    output logic signed [31:0]      result_value,
    output logic [7:0]              next_link,
    output logic [7:0]              prev_link,
    output logic [7:0]              element_count
);
    import allm_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int WM_W   = $clog2(CAPACITY + 2);
    localparam int CMP_W  = (WM_W > 8) ? WM_W + 1 : 9;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;

    logic [SLOT_W-1:0]     nxt_mem  [0:CAPACITY];
    logic [SLOT_W-1:0]     prv_mem  [0:CAPACITY];
    logic                  used_mem [0:CAPACITY];
    logic [DATA_WIDTH-1:0] val_mem  [0:CAPACITY];

    logic [2:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     free_head_reg, free_head_next;
    logic [WM_W-1:0]       wm_reg, wm_next;
    logic [SLOT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic                  done_reg, done_next;

    opcode_t               op_reg, op_next;
    logic [7:0]            slot_reg, slot_next;
    logic [7:0]            rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] v_reg, v_next;
    logic [SLOT_W-1:0]     a_reg, a_next;
    logic [SLOT_W-1:0]     b_reg, b_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    status_t               status_reg, status_next;
    logic [SLOT_W-1:0]     rslot_reg, rslot_next;
    logic [31:0]           rval_reg, rval_next;
    logic [SLOT_W-1:0]     rnext_reg, rnext_next;
    logic [SLOT_W-1:0]     rprev_reg, rprev_next;

    logic [SLOT_W-1:0]     rd_addr, rd_addr_reg;
    logic [SLOT_W-1:0]     rd_next_reg, rd_prev_reg;
    logic                  rd_used_reg;
    logic [DATA_WIDTH-1:0] rd_val_reg;

    logic                  nxt_we, prv_we, used_we, val_we;
    logic [SLOT_W-1:0]     nxt_wa, nxt_wd, prv_wa, prv_wd, used_wa, val_wa;
    logic                  used_wd;

    logic                  lk_fresh, lk_used;
    logic [SLOT_W-1:0]     lk_next, lk_prev;
    logic [DATA_WIDTH-1:0] lk_val;
    logic [63:0]           lk_wide, v_wide;
    logic                  slot_ok;
    logic                  do_walk, do_data, do_err;
    status_t               err_code;

    // resolve the sentinel and never-used slots over the raw store data
    always_comb
    begin
        lk_fresh = (WM_W'(rd_addr_reg) >= wm_reg);
        if (rd_addr_reg == '0)
        begin
            lk_next = head_reg;
            lk_prev = tail_reg;
            lk_used = 1'b1;
            lk_val  = '0;
        end
        else if (lk_fresh)
        begin
            lk_next = (rd_addr_reg == SLOT_W'(CAPACITY)) ? '0 : rd_addr_reg + SLOT_W'(1);
            lk_prev = '0;
            lk_used = 1'b0;
            lk_val  = '0;
        end
        else
        begin
            lk_next = rd_next_reg;
            lk_prev = rd_prev_reg;
            lk_used = rd_used_reg;
            lk_val  = rd_val_reg;
        end
        lk_wide = 64'(lk_val);
        v_wide  = 64'(v_reg);
        slot_ok = (CMP_W'(slot_reg) <= CMP_W'(CAPACITY)) && lk_used;
    end

    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        wm_next        = wm_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        done_next      = 1'b0;
        op_next        = op_reg;
        slot_next      = slot_reg;
        rem_next       = rem_reg;
        v_next         = v_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        rslot_next     = rslot_reg;
        rval_next      = rval_reg;
        rnext_next     = rnext_reg;
        rprev_next     = rprev_reg;
        rd_addr        = rd_addr_reg;
        nxt_we  = 1'b0;
        nxt_wa  = '0;
        nxt_wd  = '0;
        prv_we  = 1'b0;
        prv_wa  = '0;
        prv_wd  = '0;
        used_we = 1'b0;
        used_wa = '0;
        used_wd = 1'b0;
        val_we  = 1'b0;
        val_wa  = '0;
        do_walk  = 1'b0;
        do_data  = 1'b0;
        do_err   = 1'b0;
        err_code = ST_BAD_SLOT;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    slot_next  = slot;
                    rem_next   = position;
                    v_next     = DATA_WIDTH'(value);
                    state_next = S_CHK;
                    priority if (opcode == OP_ERASE_FRONT)
                        rd_addr = head_reg;
                    else if (opcode == OP_ERASE_BACK)
                        rd_addr = tail_reg;
                    else if (opcode == OP_FIND)
                        rd_addr = '0;
                    else
                        rd_addr = SLOT_W'(slot);
                end
            end
            S_CHK:
            begin
                unique case (op_reg)
                    OP_INS_AFTER, OP_INS_BEFORE:
                    begin
                        priority if (!slot_ok)
                            do_err = 1'b1;
                        else if (free_head_reg == '0)
                        begin
                            do_err   = 1'b1;
                            err_code = ST_FULL;
                        end
                        else
                        begin
                            a_next     = (op_reg == OP_INS_AFTER) ? rd_addr_reg : lk_prev;
                            b_next     = (op_reg == OP_INS_AFTER) ? lk_next : rd_addr_reg;
                            rd_addr    = free_head_reg;
                            state_next = S_ALLOC;
                        end
                    end
                    OP_ERASE, OP_ERASE_FRONT, OP_ERASE_BACK:
                    begin
                        if ((op_reg == OP_ERASE && !slot_ok) || rd_addr_reg == '0)
                            do_err = 1'b1;
                        else
                        begin
                            status_next = ST_OK;
                            rslot_next  = rd_addr_reg;
                            rval_next   = lk_wide[31:0];
                            rnext_next  = lk_next;
                            rprev_next  = lk_prev;
                            idx_next    = rd_addr_reg;
                            if (lk_prev == '0)
                                head_next = lk_next;
                            else
                            begin
                                nxt_we = 1'b1;
                                nxt_wa = lk_prev;
                                nxt_wd = lk_next;
                            end
                            if (lk_next == '0)
                                tail_next = lk_prev;
                            else
                            begin
                                prv_we = 1'b1;
                                prv_wa = lk_next;
                                prv_wd = lk_prev;
                            end
                            used_we    = 1'b1;
                            used_wa    = rd_addr_reg;
                            used_wd    = 1'b0;
                            state_next = S_LINK;
                        end
                    end
                    OP_READ:
                    begin
                        if (!slot_ok)
                            do_err = 1'b1;
                        else
                            do_data = 1'b1;
                    end
                    OP_FIND:
                    begin
                        if (CMP_W'(rem_reg) > CMP_W'(count_reg))
                        begin
                            do_err   = 1'b1;
                            err_code = ST_BAD_POS;
                        end
                        else
                            do_walk = 1'b1;
                    end
                    default:
                        do_err = 1'b1;
                endcase
            end
            S_ALLOC:
            begin
                free_head_next = lk_next;
                if (lk_fresh)
                    wm_next = wm_reg + WM_W'(1);
                nxt_we     = 1'b1;
                nxt_wa     = rd_addr_reg;
                nxt_wd     = b_reg;
                prv_we     = 1'b1;
                prv_wa     = rd_addr_reg;
                prv_wd     = a_reg;
                used_we    = 1'b1;
                used_wa    = rd_addr_reg;
                used_wd    = 1'b1;
                val_we     = 1'b1;
                val_wa     = rd_addr_reg;
                idx_next   = rd_addr_reg;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (op_reg == OP_INS_AFTER || op_reg == OP_INS_BEFORE)
                begin
                    if (a_reg == '0)
                        head_next = idx_reg;
                    else
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = a_reg;
                        nxt_wd = idx_reg;
                    end
                    if (b_reg == '0)
                        tail_next = idx_reg;
                    else
                    begin
                        prv_we = 1'b1;
                        prv_wa = b_reg;
                        prv_wd = idx_reg;
                    end
                    count_next  = count_reg + SLOT_W'(1);
                    status_next = ST_OK;
                    rslot_next  = idx_reg;
                    rval_next   = v_wide[31:0];
                    rnext_next  = b_reg;
                    rprev_next  = a_reg;
                end
                else
                begin
                    nxt_we         = 1'b1;
                    nxt_wa         = idx_reg;
                    nxt_wd         = free_head_reg;
                    free_head_next = idx_reg;
                    count_next     = count_reg - SLOT_W'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
                do_walk = 1'b1;
            default:
                state_next = S_IDLE;
        endcase

        if (do_walk)
        begin
            if (rem_reg == '0)
                do_data = 1'b1;
            else
            begin
                rd_addr    = lk_next;
                rem_next   = rem_reg - 8'd1;
                state_next = S_WALK;
            end
        end

        if (do_data)
        begin
            status_next = ST_OK;
            rslot_next  = rd_addr_reg;
            rval_next   = lk_wide[31:0];
            rnext_next  = lk_next;
            rprev_next  = lk_prev;
            done_next   = 1'b1;
            state_next  = S_IDLE;
        end

        if (do_err)
        begin
            status_next = err_code;
            rslot_next  = '0;
            rval_next   = '0;
            rnext_next  = '0;
            rprev_next  = '0;
            done_next   = 1'b1;
            state_next  = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= SLOT_W'(1);
            wm_reg        <= WM_W'(1);
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            done_reg      <= 1'b0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            wm_reg        <= wm_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            done_reg      <= done_next;
            rd_addr_reg   <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        rem_reg    <= rem_next;
        v_reg      <= v_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rslot_reg  <= rslot_next;
        rval_reg   <= rval_next;
        rnext_reg  <= rnext_next;
        rprev_reg  <= rprev_next;
    end

    always_ff @(posedge clk)
    begin
        rd_next_reg <= nxt_mem[rd_addr];
        rd_prev_reg <= prv_mem[rd_addr];
        rd_used_reg <= used_mem[rd_addr];
        rd_val_reg  <= val_mem[rd_addr];
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we)
            prv_mem[prv_wa] <= prv_wd;
        if (used_we)
            used_mem[used_wa] <= used_wd;
        if (val_we)
            val_mem[val_wa] <= v_reg;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign result_slot   = 8'(rslot_reg);
    assign result_value  = rval_reg;
    assign next_link     = 8'(rnext_reg);
    assign prev_link     = 8'(rprev_reg);
    assign element_count = 8'(count_reg);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted word did not occupy the sequencer");

    a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg == '0 || WM_W'(free_head_reg) <= wm_reg)
        else $error("free head above high-water mark");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        WM_W'(count_reg) <= WM_W'(CAPACITY))
        else $error("element count above capacity");

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import allm_pkg::*;

    localparam opcode_t OP_UNUSED   = 3'd7;
    localparam int      QUIET_LIMIT = 2000;
    localparam int      LAST_SLOT   = 255;

    typedef struct packed {
        status_t     status;
        logic [7:0]  slot;
        logic [31:0] value;
        logic [7:0]  next_slot;
        logic [7:0]  prev_slot;
        logic [7:0]  elems;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    opcode_t            opcode = OP_READ;
    logic [7:0]         slot = 8'd0;
    logic [7:0]         position = 8'd0;
    logic signed [31:0] value = 32'sd0;
    logic               done;
    status_t            status;
    logic [7:0]         result_slot;
    logic signed [31:0] result_value;
    logic [7:0]         next_link;
    logic [7:0]         prev_link;
    logic [7:0]         element_count;

    logic [31:0] slot_value [256];
    logic [7:0]  link_next [256];
    logic [7:0]  link_prev [256];
    bit          slot_taken [256];
    logic [7:0]  free_first;
    logic [7:0]  list_count;

    list_result_t pending_results[$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           gap_pct = 0;

    array_linked_list_manager_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .slot          (slot),
        .position      (position),
        .value         (value),
        .done          (done),
        .status        (status),
        .result_slot   (result_slot),
        .result_value  (result_value),
        .next_link     (next_link),
        .prev_link     (prev_link),
        .element_count (element_count)
    );

    always #2 clk = ~clk;

    function automatic void reset_list_state();
        for (int i = 0; i < 256; i++)
        begin
            slot_value[i] = 32'd0;
            link_next[i]  = 8'(i + 1);
            link_prev[i]  = 8'd0;
            slot_taken[i] = 1'b0;
        end
        link_next[0]         = 8'd0;
        link_next[LAST_SLOT] = 8'd0;
        slot_taken[0]        = 1'b1;
        free_first           = 8'd1;
        list_count           = 8'd0;
    endfunction

    function automatic list_result_t slot_view(status_t st, logic [7:0] s);
        list_result_t r;
        r.status    = st;
        r.slot      = s;
        r.value     = slot_value[s];
        r.next_slot = link_next[s];
        r.prev_slot = link_prev[s];
        r.elems     = list_count;
        return r;
    endfunction

    function automatic list_result_t apply_list_op(opcode_t op, logic [7:0] s,
                                                   logic [7:0] p, logic [31:0] v);
        list_result_t r;
        logic [7:0]   idx;
        logic [7:0]   nw;
        logic [7:0]   nb;
        logic [7:0]   pv;
        r = '0;
        r.status = ST_BAD_SLOT;
        r.elems  = list_count;
        case (op)
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                if (!slot_taken[s])
                    return r;
                if (free_first == 8'd0)
                begin
                    r.status = ST_FULL;
                    return r;
                end
                nw = free_first;
                free_first = link_next[nw];
                slot_value[nw] = v;
                slot_taken[nw] = 1'b1;
                if (op == OP_INS_AFTER)
                begin
                    nb = link_next[s];
                    link_next[s]  = nw;
                    link_prev[nw] = s;
                    link_next[nw] = nb;
                    link_prev[nb] = nw;
                end
                else
                begin
                    pv = link_prev[s];
                    link_prev[s]  = nw;
                    link_next[nw] = s;
                    link_prev[nw] = pv;
                    link_next[pv] = nw;
                end
                list_count++;
                return slot_view(ST_OK, nw);
            end
            OP_ERASE, OP_ERASE_FRONT, OP_ERASE_BACK:
            begin
                if (op == OP_ERASE)
                begin
                    if (!slot_taken[s])
                        return r;
                    idx = s;
                end
                else
                    idx = (op == OP_ERASE_FRONT) ? link_next[0] : link_prev[0];
                if (idx == 8'd0)
                    return r;
                r  = slot_view(ST_OK, idx);
                nb = link_next[idx];
                pv = link_prev[idx];
                link_prev[nb] = pv;
                link_next[pv] = nb;
                slot_taken[idx] = 1'b0;
                link_prev[idx]  = 8'd0;
                link_next[idx]  = free_first;
                free_first = idx;
                list_count--;
                r.elems = list_count;
                return r;
            end
            OP_READ:
            begin
                if (!slot_taken[s])
                    return r;
                return slot_view(ST_OK, s);
            end
            OP_FIND:
            begin
                if (p > list_count)
                begin
                    r.status = ST_BAD_POS;
                    return r;
                end
                idx = 8'd0;
                for (int i = 0; i < p; i++)
                    idx = link_next[idx];
                return slot_view(ST_OK, idx);
            end
            default:
                return r;
        endcase
    endfunction

    function automatic logic [7:0] pick_list_slot();
        logic [7:0] idx;
        int         steps;
        idx   = 8'd0;
        steps = $urandom_range(0, list_count);
        for (int i = 0; i < steps; i++)
            idx = link_next[idx];
        return idx;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    task automatic send_word(opcode_t op, logic [7:0] s, logic [7:0] p, logic [31:0] v);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        slot     <= s;
        position <= p;
        value    <= v;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_list_op(op, s, p, v));
    endtask

    task automatic send_probe();
        if ($urandom_range(0, 1))
            send_word(OP_READ, pick_list_slot(), 8'($urandom), $urandom);
        else
            send_word(OP_FIND, 8'($urandom), 8'($urandom_range(0, list_count)), $urandom);
    endtask

    task automatic test_directed();
        send_word(OP_READ, 8'd0, 8'd0, 32'd0);
        send_word(OP_ERASE_FRONT, 8'd0, 8'd0, 32'd0);
        send_word(OP_ERASE_BACK, 8'd0, 8'd0, 32'd0);
        send_word(OP_FIND, 8'd0, 8'd0, 32'd0);
        send_word(OP_FIND, 8'd0, 8'd255, 32'd0);
        send_word(OP_ERASE, 8'd0, 8'd0, 32'd0);
        send_word(OP_READ, 8'd255, 8'd0, 32'd0);
        send_word(OP_UNUSED, 8'd255, 8'd255, 32'hffff_ffff);
        send_word(OP_INS_AFTER, 8'd0, 8'd0, 32'h8000_0000);
        send_word(OP_INS_BEFORE, 8'd0, 8'd0, 32'h7fff_ffff);
        send_word(OP_INS_AFTER, 8'd1, 8'd0, 32'hffff_ffff);
        send_word(OP_INS_BEFORE, 8'd1, 8'd0, 32'h0000_0000);
        send_word(OP_INS_AFTER, 8'd200, 8'd0, 32'h1234_5678);
        send_word(OP_READ, 8'd1, 8'd0, 32'd0);
        send_word(OP_READ, 8'd0, 8'd0, 32'd0);
        send_word(OP_FIND, 8'd0, 8'd4, 32'd0);
        send_word(OP_FIND, 8'd0, 8'd5, 32'd0);
        send_word(OP_ERASE, 8'd3, 8'd0, 32'd0);
        send_word(OP_ERASE, 8'd3, 8'd0, 32'd0);
        send_word(OP_ERASE_FRONT, 8'd0, 8'd0, 32'd0);
        send_word(OP_ERASE_BACK, 8'd0, 8'd0, 32'd0);
        send_word(OP_READ, 8'd1, 8'd0, 32'd0);
        send_word(OP_ERASE_BACK, 8'd0, 8'd0, 32'd0);
        send_word(OP_ERASE_FRONT, 8'd0, 8'd0, 32'd0);
    endtask

    task automatic test_fill_to_capacity();
        opcode_t op;
        while (list_count != 8'd255)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                op = $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
                send_word(op, pick_list_slot(), 8'($urandom), $urandom);
            end
            else
                send_probe();
        end
        repeat (4)
            send_word(OP_INS_AFTER, pick_list_slot(), 8'($urandom), $urandom);
        send_word(OP_INS_BEFORE, 8'd0, 8'd0, $urandom);
        send_word(OP_FIND, 8'd0, 8'd255, 32'd0);
        send_word(OP_READ, 8'd255, 8'd0, 32'd0);
    endtask

    task automatic test_drain();
        int pick;
        while (list_count != 8'd0)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 6)
                send_word(OP_ERASE, pick_list_slot(), 8'($urandom), $urandom);
            else if (pick < 11)
                send_word(OP_ERASE_FRONT, 8'($urandom), 8'($urandom), $urandom);
            else if (pick < 17)
                send_word(OP_ERASE_BACK, 8'($urandom), 8'($urandom), $urandom);
            else if (pick == 17)
                send_word(OP_INS_AFTER, pick_list_slot(), 8'($urandom), $urandom);
            else
                send_probe();
        end
        send_word(OP_ERASE_FRONT, 8'd0, 8'd0, 32'd0);
        send_word(OP_ERASE_BACK, 8'd0, 8'd0, 32'd0);
    endtask

    task automatic test_mixed_ops(int n);
        logic [7:0] s;
        logic [7:0] p;
        for (int i = 0; i < n; i++)
        begin
            s = $urandom_range(0, 1) ? pick_list_slot() : 8'($urandom);
            p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, list_count));
            send_word(opcode_t'($urandom_range(0, 7)), s, p, $urandom);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t exp;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing outstanding");
                mismatches++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("status", 32'(exp.status), 32'(status));
                check_field("result_slot", 32'(exp.slot), 32'(result_slot));
                check_field("result_value", exp.value, result_value);
                check_field("next_link", 32'(exp.next_slot), 32'(next_link));
                check_field("prev_link", 32'(exp.prev_slot), 32'(prev_link));
                check_field("element_count", 32'(exp.elems), 32'(element_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        reset_list_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 20;
        test_directed();
        test_fill_to_capacity();
        gap_pct = 46;
        test_drain();
        gap_pct = 0;
        test_mixed_ops(150);

        start <= 1'b0;
        // drain outstanding words, then allow the longest walk to settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
